// ===== rtl/trfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfe_pkg
// Shared codes, constants and types of the tri-state remote frame encoder.
// ----------------------------------------------------------------------------
package trfe_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SYM  = 2'd1;
  localparam logic [1:0] OP_HDR  = 2'd2;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_FORCE  = 1'b1;

  localparam logic [1:0] MODE_TRI  = 2'd0;
  localparam logic [1:0] MODE_FAST = 2'd1;

  localparam logic [1:0] SYM_ZERO  = 2'd0;
  localparam logic [1:0] SYM_ONE   = 2'd1;
  localparam logic [1:0] SYM_FLOAT = 2'd2;

  localparam int SLOTS_PER_SYMBOL = 8;
  localparam int SLOT_W           = 3;
  localparam int BUS_W            = 4;
  localparam int SYMV_W           = 2;
  localparam int LEN_IN_W         = 5;
  localparam int POS_OUT_W        = 10;

  localparam logic [SLOTS_PER_SYMBOL-1:0] FAST_SQUARE = 8'hAA;
  localparam logic [SLOTS_PER_SYMBOL-1:0] SLOW_SQUARE = 8'hCC;

  localparam logic [1:0]          HDR_MODE_RST = MODE_FAST;
  localparam logic [LEN_IN_W-1:0] HDR_LEN_RST  = 5'd16;
  localparam logic [BUS_W-1:0]    ENABLE_RST   = 4'hF;
  localparam logic [BUS_W-1:0]    FORCE_RST    = 4'h0;

  typedef struct packed {
    logic                sym_we;
    logic                hdr_we;
    logic [SYMV_W-1:0]   sym_value;
    logic [1:0]          mode;
    logic [LEN_IN_W-1:0] len;
  } trfe_wr_t;

  function automatic logic [SLOTS_PER_SYMBOL-1:0] tri_pattern(input logic [SYMV_W-1:0] sym);
    logic [SLOTS_PER_SYMBOL-1:0] pat;
    case (sym)
      SYM_ZERO:  pat = 8'h11;
      SYM_ONE:   pat = 8'h77;
      SYM_FLOAT: pat = 8'h71;
      default:   pat = 8'h17;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/trfe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trfe_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/trfe_pos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfe_pos
// Slot position counter, kept as frame, symbol and slot digits plus the
// linear position.
// ----------------------------------------------------------------------------
module trfe_pos #(
  parameter int FRAMES        = 3,
  parameter int FRAME_SYMBOLS = 32,
  localparam int FR_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int SYM_W = $clog2(FRAME_SYMBOLS),
  localparam int TOTAL = FRAMES * FRAME_SYMBOLS * trfe_pkg::SLOTS_PER_SYMBOL,
  localparam int POS_W = $clog2(TOTAL)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  output logic [FR_W-1:0]             frame,
  output logic [SYM_W-1:0]            sym,
  output logic [trfe_pkg::SLOT_W-1:0] slot,
  output logic [POS_W-1:0]            pos
);

  import trfe_pkg::*;

  logic [FR_W-1:0]   frame_r;
  logic [SYM_W-1:0]  sym_r;
  logic [SLOT_W-1:0] slot_r;
  logic [POS_W-1:0]  pos_r;
  logic              slot_last;
  logic              sym_last;
  logic              frame_last;

  assign slot_last  = (slot_r == SLOT_W'(SLOTS_PER_SYMBOL - 1));
  assign sym_last   = (sym_r == SYM_W'(FRAME_SYMBOLS - 1));
  assign frame_last = (frame_r == FR_W'(FRAMES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      sym_r   <= '0;
      slot_r  <= '0;
      pos_r   <= '0;
    end else if (adv) begin
      slot_r <= slot_r + 1'b1;
      pos_r  <= (pos_r == POS_W'(TOTAL - 1)) ? '0 : pos_r + 1'b1;
      if (slot_last) begin
        sym_r <= sym_last ? '0 : sym_r + 1'b1;
        if (sym_last) begin
          frame_r <= frame_last ? '0 : frame_r + 1'b1;
        end
      end
    end
  end

  assign frame = frame_r;
  assign sym   = sym_r;
  assign slot  = slot_r;
  assign pos   = pos_r;

endmodule

// ===== rtl/trfe_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfe_lane
// One channel: symbol RAM, frame headers and the slot level of the waveform.
// ----------------------------------------------------------------------------
module trfe_lane #(
  parameter int FRAMES        = 3,
  parameter int FRAME_SYMBOLS = 32,
  localparam int FR_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int SYM_W = $clog2(FRAME_SYMBOLS),
  localparam int DEPTH = FRAMES * FRAME_SYMBOLS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  trfe_pkg::trfe_wr_t          wr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [FR_W-1:0]             wr_frame,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic [FR_W-1:0]             rd_frame,
  input  logic [SYM_W-1:0]            s1_sym,
  input  logic [trfe_pkg::SLOT_W-1:0] s1_slot,
  output logic                        level
);

  import trfe_pkg::*;

  logic [1:0]          hdr_mode_r [FRAMES];
  logic [LEN_IN_W-1:0] hdr_len_r  [FRAMES];
  logic [1:0]          s1_mode_r;
  logic [SYM_W-1:0]    s1_len_r;
  logic [SYM_W-1:0]    len_nxt;
  logic [SYMV_W-1:0]   sym_q;
  logic [SLOTS_PER_SYMBOL-1:0] pat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < FRAMES; f++) begin
        hdr_mode_r[f] <= HDR_MODE_RST;
        hdr_len_r[f]  <= HDR_LEN_RST;
      end
    end else if (wr.hdr_we) begin
      hdr_mode_r[wr_frame] <= wr.mode;
      hdr_len_r[wr_frame]  <= wr.len;
    end
  end

  assign len_nxt = (int'(hdr_len_r[rd_frame]) > FRAME_SYMBOLS - 1) ?
                   SYM_W'(FRAME_SYMBOLS - 1) : SYM_W'(hdr_len_r[rd_frame]);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_mode_r <= hdr_mode_r[rd_frame];
      s1_len_r  <= len_nxt;
    end
  end

  trfe_ram #(
    .WIDTH (SYMV_W),
    .DEPTH (DEPTH)
  ) u_sym_ram (
    .clk   (clk),
    .we    (wr.sym_we),
    .waddr (wr_addr),
    .wdata (wr.sym_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (sym_q)
  );

  always_comb begin
    case (s1_mode_r)
      MODE_TRI:  pat = tri_pattern(sym_q);
      MODE_FAST: pat = FAST_SQUARE;
      default:   pat = SLOW_SQUARE;
    endcase
    if (s1_sym < s1_len_r) begin
      level = pat[s1_slot];
    end else begin
      level = (s1_mode_r == MODE_TRI) && (s1_sym == s1_len_r) && (s1_slot == '0);
    end
  end

endmodule

// ===== rtl/tristate_remote_frame_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tristate_remote_frame_encoder_top
// Four-bit remote-control waveform generator with per-channel tri-state code
// frames. Takes one item per clock while in_stall is low; a tick's result
// passes through the registered read of the per-channel symbol RAM and then
// the result register. Write items give no result. After reset the symbol
// RAMs are filled with float, one row per cycle over all FRAMES *
// FRAME_SYMBOLS rows (96 by default); in_stall stays high for that pass,
// while configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module tristate_remote_frame_encoder_top #(
  parameter int CHANNELS      = 4,
  parameter int FRAMES        = 3,
  parameter int FRAME_SYMBOLS = 32
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [1:0] in_channel,
  input  logic [1:0] in_frame_number,
  input  logic [4:0] in_symbol_index,
  input  logic [1:0] in_symbol_value,
  input  logic [1:0] in_frame_mode,
  input  logic [4:0] in_frame_length,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_bus_value,
  output logic [9:0] out_slot_position,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  import trfe_pkg::*;

  localparam int FR_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SYM_W  = $clog2(FRAME_SYMBOLS);
  localparam int DEPTH  = FRAMES * FRAME_SYMBOLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int TOTAL  = DEPTH * SLOTS_PER_SYMBOL;
  localparam int POS_W  = $clog2(TOTAL);
  localparam int BUS_CH = (CHANNELS < BUS_W) ? CHANNELS : BUS_W;

  logic              clr_busy_r;
  logic [AW-1:0]     clr_addr_r;
  logic [BUS_W-1:0]  enable_r;
  logic [BUS_W-1:0]  force_r;

  logic              in_acc;
  logic              tick_acc;
  logic              wr_ok;
  logic              s1_valid_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [SYM_W-1:0]  s1_sym_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_go;

  logic              out_valid_r;
  logic [BUS_W-1:0]  out_bus_r;
  logic [POS_OUT_W-1:0] out_slot_r;

  logic [FR_W-1:0]   cur_frame;
  logic [SYM_W-1:0]  cur_sym;
  logic [SLOT_W-1:0] cur_slot;
  logic [POS_W-1:0]  cur_pos;

  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [FR_W-1:0]   wr_frame;
  trfe_wr_t          wr_l   [BUS_CH];
  logic              lvl    [BUS_CH];
  logic [BUS_W-1:0]  wave;
  logic [BUS_W-1:0]  bus_nxt;

  // handshake
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (s1_valid_r && !s1_go);
  assign in_acc   = in_valid && !in_stall;
  assign tick_acc = in_acc && (in_opcode == OP_TICK);
  assign wr_ok    = in_acc && (int'(in_channel) < CHANNELS) &&
                    (int'(in_frame_number) < FRAMES);
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= ENABLE_RST;
      force_r  <= FORCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_data;
        CFG_FORCE:  force_r  <= cfg_data;
        default:    enable_r <= enable_r;
      endcase
    end
  end

  // symbol RAM fill after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  trfe_pos #(
    .FRAMES        (FRAMES),
    .FRAME_SYMBOLS (FRAME_SYMBOLS)
  ) u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (tick_acc),
    .frame (cur_frame),
    .sym   (cur_sym),
    .slot  (cur_slot),
    .pos   (cur_pos)
  );

  assign rd_addr  = AW'(AW'(cur_frame) * AW'(FRAME_SYMBOLS) + AW'(cur_sym));
  assign wr_frame = FR_W'(in_frame_number);
  assign wr_addr  = clr_busy_r ? clr_addr_r :
                    AW'(AW'(wr_frame) * AW'(FRAME_SYMBOLS) + AW'(in_symbol_index));

  always_comb begin
    for (int l = 0; l < BUS_CH; l++) begin
      wr_l[l].sym_we    = clr_busy_r ||
                          (wr_ok && (in_opcode == OP_SYM) && (in_channel == 2'(l)) &&
                           (int'(in_symbol_index) < FRAME_SYMBOLS));
      wr_l[l].hdr_we    = wr_ok && (in_opcode == OP_HDR) && (in_channel == 2'(l));
      wr_l[l].sym_value = clr_busy_r ? SYM_FLOAT : in_symbol_value;
      wr_l[l].mode      = in_frame_mode;
      wr_l[l].len       = in_frame_length;
    end
  end

  for (genvar g = 0; g < BUS_CH; g++) begin : g_lane
    trfe_lane #(
      .FRAMES        (FRAMES),
      .FRAME_SYMBOLS (FRAME_SYMBOLS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr       (wr_l[g]),
      .wr_addr  (wr_addr),
      .wr_frame (wr_frame),
      .rd_en    (tick_acc),
      .rd_addr  (rd_addr),
      .rd_frame (cur_frame),
      .s1_sym   (s1_sym_r),
      .s1_slot  (s1_slot_r),
      .level    (lvl[g])
    );
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (tick_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_pos_r  <= cur_pos;
      s1_sym_r  <= cur_sym;
      s1_slot_r <= cur_slot;
    end
  end

  always_comb begin
    wave = '0;
    for (int l = 0; l < BUS_CH; l++) begin
      wave[l] = lvl[l];
    end
  end

  assign bus_nxt = (wave & enable_r) | force_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_bus_r  <= bus_nxt;
      out_slot_r <= POS_OUT_W'(s1_pos_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bus_value     = out_bus_r;
  assign out_slot_position = out_slot_r;

  // checks
  a_pos_moves_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_acc |=> $stable(cur_pos))
    else $error("slot position moved without a tick transfer");

  a_fill_ends_at_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_addr_r) == AW'(DEPTH - 1)))
    else $error("symbol RAM fill ended early");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while both stages are full");

  a_result_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_valid_r))
    else $error("result without a pending read stage");

endmodule
